// ===== rtl/core/limit_order_book_levels_core_assert.svh =====
// assertion macros shared by the core
`ifndef LIMIT_ORDER_BOOK_LEVELS_CORE_ASSERT_SVH
`define LIMIT_ORDER_BOOK_LEVELS_CORE_ASSERT_SVH

// same-cycle implication
`define LOBL_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LOBL_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lobl_pkg.sv =====
`timescale 1ns / 1ps
package lobl_pkg;

   localparam int SYMBOLS_DEF         = 8;
   localparam int LEVELS_PER_SIDE_DEF = 16;
   localparam int ORDER_SLOTS_DEF     = 1024;

   localparam logic [47:0] VOL_MAX = 48'hFFFF_FFFF_FFFF;

   localparam logic [2:0] REQ_ADD     = 3'd0;
   localparam logic [2:0] REQ_REDUCE  = 3'd1;
   localparam logic [2:0] REQ_DELETE  = 3'd2;
   localparam logic [2:0] REQ_MODIFY  = 3'd3;
   localparam logic [2:0] REQ_REPLACE = 3'd4;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_UPDATE = 2'd1;
   localparam logic [1:0] KIND_DELETE = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_SLOT    = 2'd3;

   typedef struct packed {
      logic        valid;
      logic [2:0]  sym;
      logic        side;
      logic [31:0] price;
      logic [31:0] qty;
      logic [63:0] id;
   } slot_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] price;
      logic [47:0] volume;
   } lvl_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [2:0]  sym;
      logic        side;
      logic [31:0] price;
      logic [47:0] volume;
      logic        top;
      logic [31:0] best;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   // bids rank high, asks rank low
   function automatic logic better(input logic side, input logic [31:0] a,
                                   input logic [31:0] b);
      better = side ? (a > b) : (a < b);
   endfunction

   function automatic rsp_type nc_rsp(input logic [2:0] sym, input logic side,
                                      input logic [1:0] status, input logic last);
      rsp_type r;
      r        = '0;
      r.valid  = 1'b1;
      r.kind   = KIND_NONE;
      r.sym    = sym;
      r.side   = side;
      r.status = status;
      r.last   = last;
      nc_rsp   = r;
   endfunction

endpackage

// ===== rtl/core/lobl_ram.sv =====
`timescale 1ns / 1ps
module lobl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/limit_order_book_levels_core.sv =====
`timescale 1ns / 1ps
// channel   ports                                    handshake
// request   req_type .. req_new_order_id             start high while busy low
// result    rsp_update_kind .. rsp_last              rsp_valid, one cycle each
//
// after reset a clearing pass over 2**max(slot, level address bits) entries
// (1024 by default) runs with busy high.
// an event phase keeps busy high through the slot read, a level walk reading one entry
// a cycle over all LEVELS_PER_SIDE entries, then the update; a delete of the best level adds
// a rescan of the level table, and a modify/replace with nonzero quantity that finds its order
// runs a second phase after S_NEXT. results cannot be stalled; reset is synchronous and clears
// the state, clear counter, result register, walk flag and best-level valid flags.
`include "limit_order_book_levels_core_assert.svh"
module limit_order_book_levels_core #(
   parameter int SYMBOLS         = lobl_pkg::SYMBOLS_DEF,
   parameter int LEVELS_PER_SIDE = lobl_pkg::LEVELS_PER_SIDE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [63:0] req_order_id,
   input  logic [2:0]  req_book_symbol,
   input  logic        req_buy_side,
   input  logic [31:0] req_order_price,
   input  logic [31:0] req_order_qty,
   input  logic [63:0] req_new_order_id,
   output logic        rsp_valid,
   output logic [1:0]  rsp_update_kind,
   output logic [2:0]  rsp_out_symbol,
   output logic        rsp_out_buy_side,
   output logic [31:0] rsp_level_price,
   output logic [47:0] rsp_level_volume,
   output logic        rsp_top_of_book,
   output logic [31:0] rsp_best_price,
   output logic [1:0]  rsp_status,
   output logic        rsp_last
);

   // slot index is the low bits of the order id, so the slot count stays a power of two
   localparam int ORDER_SLOTS = lobl_pkg::ORDER_SLOTS_DEF;
   localparam int SLOT_W  = $clog2(ORDER_SLOTS);
   localparam int LVL_W   = (LEVELS_PER_SIDE > 1) ? $clog2(LEVELS_PER_SIDE) : 1;
   localparam int SYM_W   = (SYMBOLS <= 2) ? 1 : ((SYMBOLS <= 4) ? 2 : 3);
   localparam int BOOK_W  = SYM_W + 1;
   localparam int LADDR_W = BOOK_W + LVL_W;
   localparam int NB      = 1 << BOOK_W;
   localparam int CLR_W   = (SLOT_W > LADDR_W) ? SLOT_W : LADDR_W;
   localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS_PER_SIDE - 1);
   localparam logic [LVL_W:0]   LVL_CNT  = (LVL_W + 1)'(LEVELS_PER_SIDE);

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_SLOT   = 7'b0000100,
      S_SCAN   = 7'b0001000,
      S_APPLY  = 7'b0010000,
      S_RESCAN = 7'b0100000,
      S_NEXT   = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [2:0]        typ_ff, typ_in;
   logic [63:0]       id_ff, id_in, nid_ff, nid_in, cur_id_ff, cur_id_in;
   logic [2:0]        sym_ff, sym_in;
   logic              side_ff, side_in, cur_side_ff, cur_side_in;
   logic [31:0]       price_ff, price_in, qty_ff, qty_in;
   logic [31:0]       tgt_ff, tgt_in, amt_ff, amt_in;
   logic              add_ph_ff, add_ph_in;
   lobl_pkg::slot_type slot_ff, slot_in;
   logic [LVL_W:0]    cnt_ff, cnt_in;
   logic              chk_ff, chk_in;
   logic [LVL_W-1:0]  chk_idx_ff, chk_idx_in;
   logic              found_ff, found_in, free_ff, free_in, rs_ok_ff, rs_ok_in;
   logic [LVL_W-1:0]  found_idx_ff, found_idx_in, free_idx_ff, free_idx_in;
   logic [LVL_W-1:0]  rs_idx_ff, rs_idx_in;
   logic [47:0]       found_vol_ff, found_vol_in;
   logic [31:0]       rs_price_ff, rs_price_in, del_price_ff, del_price_in;
   logic [CLR_W-1:0]  clr_ff, clr_in;
   lobl_pkg::rsp_type rsp_ff, rsp_in;

   logic              best_ok_ff    [NB];
   logic [LVL_W-1:0]  best_idx_ff   [NB];
   logic [31:0]       best_price_ff [NB];
   logic              best_we, best_wok;
   logic [LVL_W-1:0]  best_widx;
   logic [31:0]       best_wprice;

   logic               slot_we;
   logic [SLOT_W-1:0]  slot_waddr, slot_raddr;
   lobl_pkg::slot_type slot_wdata, slot_rd;
   logic               lvl_we;
   logic [LADDR_W-1:0] lvl_waddr, lvl_raddr;
   lobl_pkg::lvl_type  lvl_wdata, lvl_rd;

   logic [BOOK_W-1:0] bk;
   logic [63:0]       next_id;
   logic              more, hit, top, becomes;
   logic [31:0]       newq;
   logic [47:0]       newvol;
   logic [48:0]       sum;

   lobl_ram #(.WIDTH($bits(lobl_pkg::slot_type)), .DEPTH(1 << SLOT_W)) u_slot_ram (
      .clock(clock), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
      .raddr(slot_raddr), .rdata(slot_rd)
   );

   lobl_ram #(.WIDTH($bits(lobl_pkg::lvl_type)), .DEPTH(1 << LADDR_W)) u_lvl_ram (
      .clock(clock), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
      .raddr(lvl_raddr), .rdata(lvl_rd)
   );

   assign bk      = {sym_ff[SYM_W-1:0], cur_side_ff};
   assign next_id = (typ_ff == lobl_pkg::REQ_MODIFY) ? id_ff : nid_ff;
   assign more    = !add_ph_ff && (typ_ff == lobl_pkg::REQ_MODIFY ||
                    typ_ff == lobl_pkg::REQ_REPLACE) && (qty_ff != 32'd0);
   assign hit     = chk_ff && lvl_rd.valid && (lvl_rd.price == tgt_ff);
   assign newq    = slot_ff.qty - amt_ff;
   assign sum     = {1'b0, found_vol_ff} + {17'd0, qty_ff};
   assign top     = best_ok_ff[bk] && (best_idx_ff[bk] == found_idx_ff);
   assign becomes = !best_ok_ff[bk] ||
                    lobl_pkg::better(cur_side_ff, tgt_ff, best_price_ff[bk]);

   always_comb begin
      state_in     = state_ff;
      typ_in       = typ_ff;
      id_in        = id_ff;
      nid_in       = nid_ff;
      cur_id_in    = cur_id_ff;
      sym_in       = sym_ff;
      side_in      = side_ff;
      cur_side_in  = cur_side_ff;
      price_in     = price_ff;
      qty_in       = qty_ff;
      tgt_in       = tgt_ff;
      amt_in       = amt_ff;
      add_ph_in    = add_ph_ff;
      slot_in      = slot_ff;
      cnt_in       = cnt_ff;
      chk_in       = 1'b0;
      chk_idx_in   = chk_idx_ff;
      found_in     = found_ff;
      free_in      = free_ff;
      rs_ok_in     = rs_ok_ff;
      found_idx_in = found_idx_ff;
      free_idx_in  = free_idx_ff;
      rs_idx_in    = rs_idx_ff;
      found_vol_in = found_vol_ff;
      rs_price_in  = rs_price_ff;
      del_price_in = del_price_ff;
      clr_in       = clr_ff;
      rsp_in       = rsp_ff;
      rsp_in.valid = 1'b0;
      best_we      = 1'b0;
      best_wok     = 1'b0;
      best_widx    = found_idx_ff;
      best_wprice  = tgt_ff;
      slot_we      = 1'b0;
      slot_waddr   = cur_id_ff[SLOT_W-1:0];
      slot_wdata   = slot_ff;
      slot_raddr   = (state_ff == S_NEXT) ? next_id[SLOT_W-1:0]
                                          : req_order_id[SLOT_W-1:0];
      lvl_we       = 1'b0;
      lvl_waddr    = {bk, found_idx_ff};
      lvl_wdata    = '0;
      lvl_raddr    = {bk, cnt_ff[LVL_W-1:0]};
      newvol       = 48'd0;

      // level walk: one read issued and one checked per cycle
      if (state_ff == S_SCAN || state_ff == S_RESCAN) begin
         if (cnt_ff < LVL_CNT) begin
            chk_in     = 1'b1;
            chk_idx_in = cnt_ff[LVL_W-1:0];
            cnt_in     = cnt_ff + 1'b1;
         end
      end

      unique case (state_ff)
         S_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = clr_ff[SLOT_W-1:0];
            slot_wdata = '0;
            lvl_we     = 1'b1;
            lvl_waddr  = clr_ff[LADDR_W-1:0];
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == {CLR_W{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               typ_in      = req_type;
               id_in       = req_order_id;
               nid_in      = req_new_order_id;
               cur_id_in   = req_order_id;
               sym_in      = req_book_symbol;
               side_in     = req_buy_side;
               cur_side_in = req_buy_side;
               price_in    = req_order_price;
               qty_in      = req_order_qty;
               add_ph_in   = (req_type == lobl_pkg::REQ_ADD);
               if (req_type > lobl_pkg::REQ_REPLACE) begin
                  rsp_in = lobl_pkg::nc_rsp(req_book_symbol, req_buy_side,
                                            lobl_pkg::ST_OK, 1'b1);
               end else if (32'(req_book_symbol) >= SYMBOLS) begin
                  rsp_in = lobl_pkg::nc_rsp(req_book_symbol, req_buy_side,
                                            lobl_pkg::ST_UNKNOWN, 1'b1);
               end else begin
                  state_in = S_SLOT;
               end
            end
         end
         S_NEXT: begin
            add_ph_in = 1'b1;
            cur_id_in = next_id;
            state_in  = S_SLOT;
         end
         S_SLOT: begin
            cnt_in   = '0;
            found_in = 1'b0;
            free_in  = 1'b0;
            if (add_ph_ff) begin
               tgt_in = price_ff;
               if (qty_ff == 32'd0) begin
                  rsp_in   = lobl_pkg::nc_rsp(sym_ff, cur_side_ff, lobl_pkg::ST_OK, 1'b1);
                  state_in = S_IDLE;
               end else if (slot_rd.valid) begin
                  rsp_in   = lobl_pkg::nc_rsp(sym_ff, cur_side_ff, lobl_pkg::ST_SLOT, 1'b1);
                  state_in = S_IDLE;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               if (!slot_rd.valid || slot_rd.id != id_ff || slot_rd.sym != sym_ff) begin
                  rsp_in   = lobl_pkg::nc_rsp(sym_ff, side_ff, lobl_pkg::ST_UNKNOWN, 1'b1);
                  state_in = S_IDLE;
               end else begin
                  slot_in     = slot_rd;
                  tgt_in      = slot_rd.price;
                  cur_side_in = slot_rd.side;
                  amt_in      = (typ_ff == lobl_pkg::REQ_REDUCE && qty_ff < slot_rd.qty)
                                ? qty_ff : slot_rd.qty;
                  state_in    = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (hit && !found_ff) begin
               found_in     = 1'b1;
               found_idx_in = chk_idx_ff;
               found_vol_in = lvl_rd.volume;
            end
            if (chk_ff && !lvl_rd.valid && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = chk_idx_ff;
            end
            if (chk_ff && chk_idx_ff == LVL_LAST) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (!add_ph_ff) begin
               slot_we          = 1'b1;
               slot_wdata.qty   = newq;
               slot_wdata.valid = found_ff && (newq != 32'd0);
               state_in         = more ? S_NEXT : S_IDLE;
               if (!found_ff) begin
                  rsp_in = lobl_pkg::nc_rsp(sym_ff, cur_side_ff, lobl_pkg::ST_OK, !more);
               end else begin
                  newvol    = (found_vol_ff > {16'd0, amt_ff}) ? found_vol_ff - {16'd0, amt_ff}
                                                               : 48'd0;
                  lvl_we    = 1'b1;
                  lvl_wdata = '{valid: newvol != 48'd0, price: tgt_ff, volume: newvol};
                  if (newvol == 48'd0 && top) begin
                     del_price_in = tgt_ff;
                     cnt_in       = '0;
                     rs_ok_in     = 1'b0;
                     state_in     = S_RESCAN;
                  end else begin
                     rsp_in        = lobl_pkg::nc_rsp(sym_ff, cur_side_ff, lobl_pkg::ST_OK,
                                                      !more);
                     rsp_in.kind   = (newvol == 48'd0) ? lobl_pkg::KIND_DELETE
                                                       : lobl_pkg::KIND_UPDATE;
                     rsp_in.price  = tgt_ff;
                     rsp_in.volume = newvol;
                     rsp_in.top    = top;
                     rsp_in.best   = best_ok_ff[bk] ? best_price_ff[bk] : 32'd0;
                  end
               end
            end else begin
               state_in   = S_IDLE;
               slot_wdata = '{valid: 1'b1, sym: sym_ff, side: cur_side_ff, price: price_ff,
                              qty: qty_ff, id: cur_id_ff};
               if (found_ff) begin
                  newvol    = sum[48] ? lobl_pkg::VOL_MAX : sum[47:0];
                  lvl_we    = 1'b1;
                  lvl_wdata = '{valid: 1'b1, price: tgt_ff, volume: newvol};
                  slot_we   = 1'b1;
                  rsp_in        = lobl_pkg::nc_rsp(sym_ff, cur_side_ff, lobl_pkg::ST_OK, 1'b1);
                  rsp_in.kind   = lobl_pkg::KIND_UPDATE;
                  rsp_in.price  = tgt_ff;
                  rsp_in.volume = newvol;
                  rsp_in.top    = top;
                  rsp_in.best   = best_ok_ff[bk] ? best_price_ff[bk] : 32'd0;
               end else if (!free_ff) begin
                  rsp_in = lobl_pkg::nc_rsp(sym_ff, cur_side_ff, lobl_pkg::ST_FULL, 1'b1);
               end else begin
                  lvl_we    = 1'b1;
                  lvl_waddr = {bk, free_idx_ff};
                  lvl_wdata = '{valid: 1'b1, price: tgt_ff, volume: {16'd0, qty_ff}};
                  slot_we   = 1'b1;
                  if (becomes) begin
                     best_we   = 1'b1;
                     best_wok  = 1'b1;
                     best_widx = free_idx_ff;
                  end
                  rsp_in        = lobl_pkg::nc_rsp(sym_ff, cur_side_ff, lobl_pkg::ST_OK, 1'b1);
                  rsp_in.kind   = lobl_pkg::KIND_ADD;
                  rsp_in.price  = tgt_ff;
                  rsp_in.volume = {16'd0, qty_ff};
                  rsp_in.top    = becomes;
                  rsp_in.best   = becomes ? tgt_ff : best_price_ff[bk];
               end
            end
         end
         S_RESCAN: begin
            if (chk_ff && lvl_rd.valid &&
                (!rs_ok_ff || lobl_pkg::better(cur_side_ff, lvl_rd.price, rs_price_ff))) begin
               rs_ok_in    = 1'b1;
               rs_idx_in   = chk_idx_ff;
               rs_price_in = lvl_rd.price;
            end
            if (chk_ff && chk_idx_ff == LVL_LAST) begin
               best_we       = 1'b1;
               best_wok      = rs_ok_in;
               best_widx     = rs_idx_in;
               best_wprice   = rs_price_in;
               rsp_in        = lobl_pkg::nc_rsp(sym_ff, cur_side_ff, lobl_pkg::ST_OK, !more);
               rsp_in.kind   = lobl_pkg::KIND_DELETE;
               rsp_in.price  = del_price_ff;
               rsp_in.top    = 1'b1;
               rsp_in.best   = rs_ok_in ? rs_price_in : 32'd0;
               state_in      = more ? S_NEXT : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         rsp_ff   <= '0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rsp_ff   <= rsp_in;
         chk_ff   <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      typ_ff       <= typ_in;
      id_ff        <= id_in;
      nid_ff       <= nid_in;
      cur_id_ff    <= cur_id_in;
      sym_ff       <= sym_in;
      side_ff      <= side_in;
      cur_side_ff  <= cur_side_in;
      price_ff     <= price_in;
      qty_ff       <= qty_in;
      tgt_ff       <= tgt_in;
      amt_ff       <= amt_in;
      add_ph_ff    <= add_ph_in;
      slot_ff      <= slot_in;
      cnt_ff       <= cnt_in;
      chk_idx_ff   <= chk_idx_in;
      found_ff     <= found_in;
      free_ff      <= free_in;
      rs_ok_ff     <= rs_ok_in;
      found_idx_ff <= found_idx_in;
      free_idx_ff  <= free_idx_in;
      rs_idx_ff    <= rs_idx_in;
      found_vol_ff <= found_vol_in;
      rs_price_ff  <= rs_price_in;
      del_price_ff <= del_price_in;
   end

   // best level per book, cached with its price
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NB; i++) begin
            best_ok_ff[i] <= 1'b0;
         end
      end else if (best_we) begin
         best_ok_ff[bk] <= best_wok;
      end
   end

   always_ff @(posedge clock) begin
      if (best_we) begin
         best_idx_ff[bk]   <= best_widx;
         best_price_ff[bk] <= best_wprice;
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_ff.valid;
   assign rsp_update_kind  = rsp_ff.kind;
   assign rsp_out_symbol   = rsp_ff.sym;
   assign rsp_out_buy_side = rsp_ff.side;
   assign rsp_level_price  = rsp_ff.price;
   assign rsp_level_volume = rsp_ff.volume;
   assign rsp_top_of_book  = rsp_ff.top;
   assign rsp_best_price   = rsp_ff.best;
   assign rsp_status       = rsp_ff.status;
   assign rsp_last         = rsp_ff.last;

   `LOBL_ASSERT_IMP(a_last_idle, clock, reset, rsp_valid && rsp_last,
      state_ff == S_IDLE, "final word while event still running")
   `LOBL_ASSERT_IMP(a_first_next, clock, reset, rsp_valid && !rsp_last,
      state_ff == S_NEXT, "first word of two not followed by second phase")
   `LOBL_ASSERT_IMP(a_none_zero, clock, reset,
      rsp_valid && rsp_update_kind == lobl_pkg::KIND_NONE,
      rsp_level_price == 32'd0 && rsp_level_volume == 48'd0 && !rsp_top_of_book,
      "no-change word carries level data")
   `LOBL_ASSERT_NXT(a_clear_quiet, clock, reset, state_ff == S_CLEAR,
      !rsp_valid, "word emitted during clearing pass")

endmodule

// ===== sim/tb_limit_order_book_levels_core.sv =====
`timescale 1ns / 1ps
module tb_limit_order_book_levels_core;

   localparam int NSYM   = lobl_pkg::SYMBOLS_DEF;
   localparam int NLVL   = lobl_pkg::LEVELS_PER_SIDE_DEF;
   localparam int NSLOT  = lobl_pkg::ORDER_SLOTS_DEF;
   localparam int NBOOK  = NSYM * 2;
   localparam int SETTLE = 150;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  sym;
      logic        side;
      logic [31:0] price;
      logic [47:0] volume;
      logic        top;
      logic [31:0] best;
      logic [1:0]  status;
      logic        last;
   } level_word_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_type;
   logic [63:0] req_order_id;
   logic [2:0]  req_book_symbol;
   logic        req_buy_side;
   logic [31:0] req_order_price;
   logic [31:0] req_order_qty;
   logic [63:0] req_new_order_id;
   logic        rsp_valid;
   logic [1:0]  rsp_update_kind;
   logic [2:0]  rsp_out_symbol;
   logic        rsp_out_buy_side;
   logic [31:0] rsp_level_price;
   logic [47:0] rsp_level_volume;
   logic        rsp_top_of_book;
   logic [31:0] rsp_best_price;
   logic [1:0]  rsp_status;
   logic        rsp_last;

   limit_order_book_levels_core dut (.*);

   // book mirror
   logic        ord_live [NSLOT];
   logic [63:0] ord_id   [NSLOT];
   logic [2:0]  ord_sym  [NSLOT];
   logic        ord_side [NSLOT];
   logic [31:0] ord_px   [NSLOT];
   logic [31:0] ord_qty  [NSLOT];
   logic        lv_on    [NBOOK*NLVL];
   logic [31:0] lv_px    [NBOOK*NLVL];
   logic [47:0] lv_vol   [NBOOK*NLVL];
   logic        top_ok   [NBOOK];
   int          top_idx  [NBOOK];

   level_word_type pending_levels[$];
   int             mismatches = 0;
   bit             gaps_on = 1'b1;

   initial forever #6 clock = ~clock;

   initial begin
      #(12.0 * 900000);
      $display("simulation failed");
      $finish;
   end

   function automatic level_word_type no_change(logic [2:0] sym, logic side,
                                                logic [1:0] st);
      level_word_type w;
      w        = '0;
      w.kind   = lobl_pkg::KIND_NONE;
      w.sym    = sym;
      w.side   = side;
      w.status = st;
      return w;
   endfunction

   function automatic logic [31:0] best_px(int bk);
      return top_ok[bk] ? lv_px[bk*NLVL + top_idx[bk]] : 32'd0;
   endfunction

   function automatic bit ranks_above(logic side, logic [31:0] a, logic [31:0] b);
      return side ? (a > b) : (a < b);
   endfunction

   function automatic int level_of(int bk, logic [31:0] px);
      for (int i = 0; i < NLVL; i++)
         if (lv_on[bk*NLVL + i] && lv_px[bk*NLVL + i] == px) return i;
      return -1;
   endfunction

   task automatic rescan_best(int bk, logic side);
      int a;
      top_ok[bk]  = 1'b0;
      top_idx[bk] = 0;
      for (int i = 0; i < NLVL; i++) begin
         a = bk*NLVL + i;
         if (lv_on[a] && (!top_ok[bk] || ranks_above(side, lv_px[a], best_px(bk)))) begin
            top_ok[bk]  = 1'b1;
            top_idx[bk] = i;
         end
      end
   endtask

   task automatic take_shares(int s, logic [31:0] amt, output level_word_type w);
      int bk, li, a;
      bit top;
      logic [1:0] kind;
      bk   = ord_sym[s]*2 + ord_side[s];
      li   = level_of(bk, ord_px[s]);
      kind = lobl_pkg::KIND_UPDATE;
      ord_qty[s] = ord_qty[s] - amt;
      if (ord_qty[s] == 0) ord_live[s] = 1'b0;
      if (li < 0) begin
         ord_live[s] = 1'b0;
         w = no_change(ord_sym[s], ord_side[s], lobl_pkg::ST_OK);
         return;
      end
      a   = bk*NLVL + li;
      top = top_ok[bk] && top_idx[bk] == li;
      lv_vol[a] = ({16'd0, amt} < lv_vol[a]) ? lv_vol[a] - amt : 48'd0;
      if (lv_vol[a] == 0) begin
         lv_on[a] = 1'b0;
         kind = lobl_pkg::KIND_DELETE;
         if (top) rescan_best(bk, ord_side[s]);
      end
      w = '{kind, ord_sym[s], ord_side[s], lv_px[a], lv_vol[a], top, best_px(bk),
            lobl_pkg::ST_OK, 1'b0};
   endtask

   task automatic add_order(logic [63:0] id, logic [2:0] sym, logic side,
                            logic [31:0] px, logic [31:0] qty, output level_word_type w);
      int s, bk, li, a;
      logic [1:0] kind;
      s    = int'(id % NSLOT);
      bk   = sym*2 + side;
      kind = lobl_pkg::KIND_UPDATE;
      if (qty == 0) begin
         w = no_change(sym, side, lobl_pkg::ST_OK);
         return;
      end
      if (ord_live[s]) begin
         w = no_change(sym, side, lobl_pkg::ST_SLOT);
         return;
      end
      li = level_of(bk, px);
      if (li >= 0) begin
         a = bk*NLVL + li;
         lv_vol[a] = (lobl_pkg::VOL_MAX - lv_vol[a] < {16'd0, qty}) ? lobl_pkg::VOL_MAX
                                                                     : lv_vol[a] + qty;
      end else begin
         for (int i = NLVL - 1; i >= 0; i--)
            if (!lv_on[bk*NLVL + i]) li = i;
         if (li < 0) begin
            w = no_change(sym, side, lobl_pkg::ST_FULL);
            return;
         end
         a = bk*NLVL + li;
         lv_on[a]  = 1'b1;
         lv_px[a]  = px;
         lv_vol[a] = {16'd0, qty};
         kind      = lobl_pkg::KIND_ADD;
         if (!top_ok[bk] || ranks_above(side, px, best_px(bk))) begin
            top_ok[bk]  = 1'b1;
            top_idx[bk] = li;
         end
      end
      ord_live[s] = 1'b1;
      ord_id[s]   = id;
      ord_sym[s]  = sym;
      ord_side[s] = side;
      ord_px[s]   = px;
      ord_qty[s]  = qty;
      w = '{kind, sym, side, px, lv_vol[a], top_ok[bk] && top_idx[bk] == li, best_px(bk),
            lobl_pkg::ST_OK, 1'b0};
   endtask

   // works out the level changes of one accepted word
   task automatic apply_book_event(logic [2:0] typ, logic [63:0] id, logic [2:0] sym,
                                   logic side, logic [31:0] px, logic [31:0] qty,
                                   logic [63:0] nid);
      level_word_type w1, w2;
      int s;
      bit two;
      logic oside;
      s   = int'(id % NSLOT);
      two = 1'b0;
      if (typ > lobl_pkg::REQ_REPLACE) w1 = no_change(sym, side, lobl_pkg::ST_OK);
      else if (typ == lobl_pkg::REQ_ADD) add_order(id, sym, side, px, qty, w1);
      else if (!ord_live[s] || ord_id[s] != id || ord_sym[s] != sym)
         w1 = no_change(sym, side, lobl_pkg::ST_UNKNOWN);
      else if (typ == lobl_pkg::REQ_REDUCE)
         take_shares(s, (qty < ord_qty[s]) ? qty : ord_qty[s], w1);
      else begin
         oside = ord_side[s];
         take_shares(s, ord_qty[s], w1);
         if (typ != lobl_pkg::REQ_DELETE && qty > 0) begin
            add_order((typ == lobl_pkg::REQ_MODIFY) ? id : nid, sym, oside, px, qty, w2);
            two = 1'b1;
         end
      end
      if (two) begin
         w2.last = 1'b1;
         pending_levels = {pending_levels, w1, w2};
      end else begin
         w1.last = 1'b1;
         pending_levels = {pending_levels, w1};
      end
   endtask

   always @(posedge clock) begin
      level_word_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_update_kind, rsp_out_symbol, rsp_out_buy_side, rsp_level_price,
                 rsp_level_volume, rsp_top_of_book, rsp_best_price, rsp_status, rsp_last};
         if (pending_levels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", got);
         end else begin
            want = pending_levels.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch kind %0d/%0d sym %0d/%0d side %0d/%0d px %h/%h",
                           want.kind, got.kind, want.sym, got.sym, want.side, got.side,
                           want.price, got.price);
                  $display("   vol %h/%h top %0d/%0d best %h/%h st %0d/%0d last %0d/%0d",
                           want.volume, got.volume, want.top, got.top, want.best,
                           got.best, want.status, got.status, want.last, got.last);
               end
            end
         end
      end
   end

   // leaves start high on return so the next word can follow at once, unless it inserts a random gap
   task automatic send_word(logic [2:0] typ, logic [63:0] id, logic [2:0] sym,
                            logic side, logic [31:0] px, logic [31:0] qty,
                            logic [63:0] nid);
      start            <= 1'b1;
      req_type         <= typ;
      req_order_id     <= id;
      req_book_symbol  <= sym;
      req_buy_side     <= side;
      req_order_price  <= px;
      req_order_qty    <= qty;
      req_new_order_id <= nid;
      do @(posedge clock); while (busy);
      apply_book_event(typ, id, sym, side, px, qty, nid);
      if (gaps_on && $urandom_range(99) < 10) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 60)) @(posedge clock);
      end
   endtask

   task automatic drain;
      start <= 1'b0;
      do @(posedge clock); while (pending_levels.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic test_directed;
      logic [63:0] big;
      big = 64'hFFFF_FFFF_FFFF_FC05;
      send_word(lobl_pkg::REQ_ADD, 64'd1, 3'd0, 1'b1, 32'd100, 32'd10, 64'd0);
      send_word(lobl_pkg::REQ_ADD, 64'd2, 3'd0, 1'b1, 32'd100, 32'd5, 64'd0);
      send_word(lobl_pkg::REQ_ADD, 64'd3, 3'd0, 1'b1, 32'd105, 32'd7, 64'd0);
      send_word(lobl_pkg::REQ_ADD, 64'd4, 3'd0, 1'b0, 32'd110, 32'd3, 64'd0);
      send_word(lobl_pkg::REQ_ADD, 64'd5, 3'd0, 1'b0, 32'd108, 32'd4, 64'd0);
      send_word(lobl_pkg::REQ_ADD, 64'd1025, 3'd0, 1'b1, 32'd90, 32'd1, 64'd0);  // same slot
      send_word(lobl_pkg::REQ_ADD, 64'd1, 3'd0, 1'b1, 32'd90, 32'd1, 64'd0);     // same id
      send_word(lobl_pkg::REQ_ADD, 64'd6, 3'd0, 1'b1, 32'd90, 32'd0, 64'd0);     // zero shares
      send_word(lobl_pkg::REQ_REDUCE, 64'd1, 3'd0, 1'b1, 32'd0, 32'd4, 64'd0);
      send_word(lobl_pkg::REQ_REDUCE, 64'd1, 3'd0, 1'b1, 32'd0, 32'hFFFF_FFFF, 64'd0);
      send_word(lobl_pkg::REQ_DELETE, 64'd3, 3'd0, 1'b0, 32'd0, 32'd0, 64'd0);   // best bid gone
      send_word(lobl_pkg::REQ_MODIFY, 64'd5, 3'd0, 1'b1, 32'd120, 32'd9, 64'd0);
      send_word(lobl_pkg::REQ_MODIFY, 64'd4, 3'd0, 1'b0, 32'd120, 32'd0, 64'd0);
      send_word(lobl_pkg::REQ_REPLACE, 64'd2, 3'd0, 1'b0, 32'd99, 32'd8, 64'd77);
      send_word(lobl_pkg::REQ_REDUCE, 64'd2, 3'd0, 1'b1, 32'd0, 32'd1, 64'd0);   // gone
      send_word(lobl_pkg::REQ_REDUCE, 64'd77, 3'd1, 1'b1, 32'd0, 32'd1, 64'd0);  // wrong book
      send_word(lobl_pkg::REQ_ADD, big, 3'd7, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
      send_word(lobl_pkg::REQ_ADD, 64'd8, 3'd7, 1'b1, 32'd0, 32'hFFFF_FFFF, 64'd0);
      send_word(lobl_pkg::REQ_REPLACE, big, 3'd7, 1'b0, 32'd0, 32'd1,
                64'hFFFF_FFFF_FFFF_FFFF);
      for (int t = 5; t < 8; t++)
         send_word(3'(t), 64'd9, 3'd2, 1'b1, 32'd1, 32'd1, 64'd0);
      drain();
   endtask

   task automatic test_table_full;
      for (int i = 0; i < NLVL + 2; i++)
         send_word(lobl_pkg::REQ_ADD, 64'(200 + i), 3'd3, 1'b0, 32'(500 - i), 32'd2, 64'd0);
      send_word(lobl_pkg::REQ_DELETE, 64'd213, 3'd3, 1'b0, 32'd0, 32'd0, 64'd0);
      send_word(lobl_pkg::REQ_ADD, 64'd230, 3'd3, 1'b0, 32'd7, 32'd2, 64'd0);
      drain();
   endtask

   task automatic test_random(int count);
      logic [2:0]  typ, sym;
      logic [63:0] id, nid;
      logic [31:0] px, qty;
      logic        side;
      int          r, s0, s;
      for (int n = 0; n < count; n++) begin
         gaps_on = !(n >= count/3 && n < count/2);     // quiet stretch
         if (n == count*2/3) drain();
         r    = $urandom_range(99);
         sym  = 3'($urandom_range(7));
         side = 1'($urandom_range(1));
         id   = {$urandom, $urandom};
         nid  = {$urandom, $urandom};
         px   = ($urandom_range(9) == 0) ? $urandom : 32'(1000 + $urandom_range(24));
         qty  = ($urandom_range(19) == 0) ? $urandom : 32'($urandom_range(1, 400));
         if ($urandom_range(19) == 0) qty = 32'd0;
         typ  = lobl_pkg::REQ_ADD;
         if (r >= 45 && r < 95) begin
            s0 = $urandom_range(NSLOT - 1);
            s  = -1;
            for (int k = 0; k < NSLOT && s < 0; k++)
               if (ord_live[(s0 + k) % NSLOT]) s = (s0 + k) % NSLOT;
            if (s >= 0) begin
               typ = 3'($urandom_range(1, 4));
               id  = ord_id[s];
               sym = ord_sym[s];
               if ($urandom_range(19) == 0) sym = sym ^ 3'd1;
               if ($urandom_range(19) == 0) id  = id ^ 64'h400;
            end
         end else if (r >= 95) typ = 3'($urandom_range(7));
         send_word(typ, id, sym, side, px, qty, nid);
      end
      drain();
   endtask

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_type         <= lobl_pkg::REQ_ADD;
      req_order_id     <= '0;
      req_book_symbol  <= '0;
      req_buy_side     <= 1'b0;
      req_order_price  <= '0;
      req_order_qty    <= '0;
      req_new_order_id <= '0;
      for (int i = 0; i < NSLOT; i++) ord_live[i] = 1'b0;
      for (int i = 0; i < NBOOK*NLVL; i++) lv_on[i] = 1'b0;
      for (int i = 0; i < NBOOK; i++) begin
         top_ok[i]  = 1'b0;
         top_idx[i] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      test_random(1100);
      if (mismatches == 0 && pending_levels.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/lobl_pkg.sv
rtl/core/lobl_ram.sv
rtl/core/limit_order_book_levels_core.sv
sim/tb_limit_order_book_levels_core.sv
